>>> rtl/core/segment_circle_collision_scan_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef SEGMENT_CIRCLE_COLLISION_SCAN_MACROS_SVH
`define SEGMENT_CIRCLE_COLLISION_SCAN_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SCC_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("scc assertion failed");

// Next-cycle implication, disabled in reset.
`define SCC_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("scc assertion failed");

`endif

>>> rtl/core/scc_pkg.sv
// Shared types and constants for the segment/circle collision scanner.
// No dependencies.
package scc_pkg;

    localparam int FIELD_W = 16;
    localparam int RSQ_W   = 30;
    localparam int HIDX_W  = 6;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_req                       req_type;
        logic signed [FIELD_W-1:0]  seg_x1;
        logic signed [FIELD_W-1:0]  seg_y1;
        logic signed [FIELD_W-1:0]  seg_x2;
        logic signed [FIELD_W-1:0]  seg_y2;
        logic signed [FIELD_W-1:0]  center_x;
        logic signed [FIELD_W-1:0]  center_y;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [HIDX_W-1:0] hit_index;
        logic              table_full_error;
    } t_out_word;

    // Control that travels with each segment through the test pipeline.
    typedef struct packed {
        logic vld;
        logic last;
    } t_probe;

endpackage

>>> rtl/core/segment_circle_collision_scan.sv
// Segment/circle collision scanner top level: control, segment table, result register.
// Depends on scc_pkg, scc_ram and scc_test.
//
// Loads, clears, unused requests and queries of an empty table write the result register
// when accepted. Other queries scan: the single read port of the segment RAM issues one
// segment per cycle into the test pipeline, and the result is written when the last
// segment leaves it. One item is worked on at a time; the input stalls while a query
// scans or while an undelivered result blocks the output register. There is no clearing
// pass: entries are read only below the count.
module segment_circle_collision_scan #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  scc_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output scc_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [scc_pkg::RSQ_W-1:0]     i_cfg_data
);
    import scc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_issue;
    logic                r_issue_done;
    logic signed [C-1:0] r_cx, r_cy;
    logic [RSQ_W-1:0]    r_rsq;
    logic                r_found;
    logic [IW-1:0]       r_fidx;
    t_out_word           r_out;
    logic                r_ovld;
    t_probe              r_rp;
    logic [IW-1:0]       r_ridx;

    logic                in_acc, out_acc, issue, issue_last, full;
    logic                scan_end;
    logic [4*C-1:0]      seg_wdata, seg_rdata;
    logic [C+FIELD_W-1:0] ex1, ey1, ex2, ey2, ecx, ecy;
    t_probe              t_probe_out;
    logic [IW-1:0]       t_idx_out;
    logic                t_hit;

    assign out_acc    = r_ovld && !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && (!r_ovld || !i_out_stall));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign full       = (r_count >= CW'(MAX_SEGMENTS));
    assign issue      = (r_state == ST_SCAN) && !r_issue_done;
    assign issue_last = (r_issue == IW'(r_count - CW'(1)));
    assign scan_end   = t_probe_out.vld && t_probe_out.last;

    // keep the low COORD_BITS of each field, taken as signed
    always_comb begin
        ex1 = {{C{1'b0}}, i_in_word.seg_x1};
        ey1 = {{C{1'b0}}, i_in_word.seg_y1};
        ex2 = {{C{1'b0}}, i_in_word.seg_x2};
        ey2 = {{C{1'b0}}, i_in_word.seg_y2};
        ecx = {{C{1'b0}}, i_in_word.center_x};
        ecy = {{C{1'b0}}, i_in_word.center_y};
        seg_wdata = {ex1[C-1:0], ey1[C-1:0], ex2[C-1:0], ey2[C-1:0]};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_word.req_type == REQ_QUERY && r_count != '0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    scc_ram #(
        .WIDTH(4 * C),
        .DEPTH(MAX_SEGMENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_in_word.req_type == REQ_LOAD && !full),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (seg_wdata),
        .i_raddr (r_issue),
        .o_rdata (seg_rdata)
    );

    scc_test #(
        .COORD_BITS(C),
        .IW        (IW)
    ) u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_probe (r_rp),
        .i_idx   (r_ridx),
        .i_seg   (seg_rdata),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_rsq   (r_rsq),
        .o_probe (t_probe_out),
        .o_idx   (t_idx_out),
        .o_hit   (t_hit)
    );

    always_ff @(posedge i_clk) begin
        r_ridx <= r_issue;
        if (in_acc && i_in_word.req_type == REQ_QUERY) begin
            r_cx <= ecx[C-1:0];
            r_cy <= ecy[C-1:0];
        end
        if (t_probe_out.vld && t_hit && !r_found) begin
            r_fidx <= t_idx_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_issue      <= '0;
            r_issue_done <= 1'b0;
            r_rsq        <= RSQ_W'(400);
            r_found      <= 1'b0;
            r_ovld       <= 1'b0;
            r_out        <= '0;
            r_rp         <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_rsq <= i_cfg_data;
            end

            r_rp.vld  <= issue;
            r_rp.last <= issue && issue_last;
            if (issue) begin
                r_issue <= r_issue + IW'(1);
                if (issue_last) begin
                    r_issue_done <= 1'b1;
                end
            end

            if (t_probe_out.vld && t_hit) begin
                r_found <= 1'b1;
            end

            if (out_acc) begin
                r_ovld <= 1'b0;
            end

            if (in_acc) begin
                r_out  <= '0;
                r_ovld <= 1'b1;
                unique case (i_in_word.req_type)
                    REQ_LOAD: begin
                        if (full) begin
                            r_out.table_full_error <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    REQ_QUERY: begin
                        // start a scan; an empty table answers at once
                        r_issue      <= '0;
                        r_issue_done <= 1'b0;
                        r_found      <= 1'b0;
                        if (r_count != '0) begin
                            r_ovld <= 1'b0;
                        end
                    end
                    REQ_CLEAR: r_count <= '0;
                    REQ_NONE: ;
                    default: ;
                endcase
            end

            if (scan_end) begin
                r_ovld           <= 1'b1;
                r_out.hit        <= r_found || t_hit;
                r_out.table_full_error <= 1'b0;
                if (r_found) begin
                    r_out.hit_index <= HIDX_W'(r_fidx);
                end else if (t_hit) begin
                    r_out.hit_index <= HIDX_W'(t_idx_out);
                end else begin
                    r_out.hit_index <= '0;
                end
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;
endmodule

>>> rtl/core/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/scc_test.sv
// Five-stage segment/circle intersection test, one segment per cycle.
// Depends on scc_pkg.
module scc_test #(
    parameter int COORD_BITS = 16,
    parameter int IW         = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scc_pkg::t_probe              i_probe,
    input  logic [IW-1:0]                i_idx,
    input  logic [4*COORD_BITS-1:0]      i_seg,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic [scc_pkg::RSQ_W-1:0]    i_rsq,
    output scc_pkg::t_probe              o_probe,
    output logic [IW-1:0]                o_idx,
    output logic                         o_hit
);
    import scc_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * C + 1;
    localparam int SW   = 2 * C + 2;
    localparam int AW   = 2 * C + 1;
    localparam int MW   = 2 * C + 1;
    localparam int CMPW = (2 * MW > AW + RSQ_W) ? 2 * MW : AW + RSQ_W;
    localparam int NST  = 5;

    t_probe        r_pv   [NST];
    logic [IW-1:0] r_pidx [NST];

    logic signed [C-1:0] x1, y1, x2, y2;
    assign {x1, y1, x2, y2} = i_seg;

    // stage 1
    logic signed [DW-1:0] r_dx, r_dy, r_fx, r_fy, r_gx, r_gy;
    // stage 2
    logic signed [PW-1:0] r_pdx, r_pdy, r_pfdx, r_pfdy, r_pff, r_pfy;
    logic signed [PW-1:0] r_pgx, r_pgy, r_pc1, r_pc2;
    // stage 3
    logic signed [SW-1:0] r_a, r_h, r_s0, r_s1, r_cr;
    // stage 4
    logic                 r_deg, r_inner, r_max_ok, r_min_else;
    logic [CMPW-1:0]      r_crsq, r_ar;
    // stage 5
    logic                 r_hit;

    logic signed [SW:0]   nh;
    logic [MW-1:0]        mag;

    always_comb begin
        nh  = -(SW+1)'(r_h);
        mag = MW'(r_cr[SW-1] ? -r_cr : r_cr);
    end

    always_ff @(posedge i_clk) begin
        r_dx <= DW'(x2) - DW'(x1);
        r_dy <= DW'(y2) - DW'(y1);
        r_fx <= DW'(x1) - DW'(i_cx);
        r_fy <= DW'(y1) - DW'(i_cy);
        r_gx <= DW'(x2) - DW'(i_cx);
        r_gy <= DW'(y2) - DW'(i_cy);

        r_pdx  <= PW'(r_dx * r_dx);
        r_pdy  <= PW'(r_dy * r_dy);
        r_pfdx <= PW'(r_fx * r_dx);
        r_pfdy <= PW'(r_fy * r_dy);
        r_pff  <= PW'(r_fx * r_fx);
        r_pfy  <= PW'(r_fy * r_fy);
        r_pgx  <= PW'(r_gx * r_gx);
        r_pgy  <= PW'(r_gy * r_gy);
        r_pc1  <= PW'(r_dx * r_fy);
        r_pc2  <= PW'(r_dy * r_fx);

        r_a  <= SW'(r_pdx) + SW'(r_pdy);
        r_h  <= SW'(r_pfdx) + SW'(r_pfdy);
        r_s0 <= SW'(r_pff) + SW'(r_pfy);
        r_s1 <= SW'(r_pgx) + SW'(r_pgy);
        r_cr <= SW'(r_pc1) - SW'(r_pc2);

        // s0 and s1 are sums of squares: compare them unsigned with r^2
        r_deg      <= (r_a == '0);
        r_inner    <= (r_h <= 0) && (nh <= (SW+1)'(r_a));
        r_max_ok   <= (r_s0[AW-1:0] >= i_rsq) || (r_s1[AW-1:0] >= i_rsq);
        r_min_else <= (r_s0[AW-1:0] <= i_rsq) || (r_s1[AW-1:0] <= i_rsq);
        r_crsq     <= CMPW'(mag * mag);
        r_ar       <= CMPW'(r_a[AW-1:0] * i_rsq);

        r_hit <= !r_deg && r_max_ok && (r_inner ? (r_crsq <= r_ar) : r_min_else);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_pv[k] <= '0;
            end
        end else begin
            r_pv[0] <= i_probe;
            for (int k = 1; k < NST; k++) begin
                r_pv[k] <= r_pv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx[0] <= i_idx;
        for (int k = 1; k < NST; k++) begin
            r_pidx[k] <= r_pidx[k-1];
        end
    end

    assign o_probe = r_pv[NST-1];
    assign o_idx   = r_pidx[NST-1];
    assign o_hit   = r_hit;
endmodule

>>> rtl/core/scc_checker.sv
// Port-level checker for the collision scanner, bound to the top level.
// Depends on scc_pkg and segment_circle_collision_scan_macros.svh.
`include "segment_circle_collision_scan_macros.svh"

module scc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input scc_pkg::t_in_word         i_in_word,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input scc_pkg::t_out_word        o_out_word,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready,
    input logic [scc_pkg::RSQ_W-1:0] i_cfg_data
);
    import scc_pkg::*;

    `SCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `SCC_ASSERT_NEXT(a_word_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_word))
    `SCC_ASSERT_NOW(a_miss_index, i_clk, i_rst_n, o_out_valid && !o_out_word.hit, o_out_word.hit_index == '0)
    `SCC_ASSERT_NOW(a_hit_no_full, i_clk, i_rst_n, o_out_valid && o_out_word.hit, !o_out_word.table_full_error)
    `SCC_ASSERT_NEXT(a_quick_result, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_word.req_type != REQ_QUERY, o_out_valid)
endmodule

bind segment_circle_collision_scan scc_checker u_scc_checker (.*);
